// File: hw/rtl/sbtc_pkg.sv
package sbtc_pkg;

	localparam int LIMIT_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 1'b1;

	localparam logic [7:0] SYM_OFFSET = 8'h3C;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic       decode_error;
	} result_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] carry_bits;
		logic       discarding;
	} codec_state_t;

	typedef struct packed {
		logic       decode_mode;
		logic [LIMIT_W-1:0] output_limit;
	} codec_cfg_t;

endpackage

// File: hw/rtl/sbtc_in_if.sv
interface sbtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

// File: hw/rtl/sbtc_out_if.sv
interface sbtc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic       decode_error;

	modport source (output valid, out_byte, out_valid, out_last, decode_error, input ready);
	modport sink (input valid, out_byte, out_valid, out_last, decode_error, output ready);
endinterface

// File: hw/rtl/sbtc_step.sv
module sbtc_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  sbtc_pkg::codec_cfg_t   cfg,
	input  sbtc_pkg::codec_state_t st,
	input  logic [COUNT_WIDTH-1:0] cnt,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	output sbtc_pkg::codec_state_t st_next,
	output logic [COUNT_WIDTH-1:0] cnt_next,
	output logic [1:0]             n_res,
	output sbtc_pkg::result_t      res0,
	output sbtc_pkg::result_t      res1
);
	import sbtc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic [COUNT_WIDTH-1:0] cnt1;
	logic may0;
	logic may1;

	assign cnt1 = cnt + 1'b1;
	assign may0 = (CMP_W'(cnt) < CMP_W'(cfg.output_limit)) && (cnt != '1);
	assign may1 = (CMP_W'(cnt1) < CMP_W'(cfg.output_limit)) && (cnt1 != '1);

	always_comb begin
		logic [1:0] r;
		logic [5:0] ch;
		logic [5:0] made;
		logic [5:0] rest;
		logic [1:0] nd;
		logic       clr;
		logic       fin;

		st_next = st;
		n_res   = 2'd0;
		nd      = 2'd0;
		res0    = '0;
		res1    = '0;
		clr     = 1'b0;
		fin     = 1'b0;
		r       = 2'd0;
		ch      = '0;
		made    = '0;
		rest    = '0;

		if (st.discarding) begin
			if (in_last) begin
				if (st.phase == 2'd1) begin
					res0.out_last = 1'b1;
					n_res = 2'd1;
				end
				clr = 1'b1;
			end
		end else if (cfg.decode_mode) begin
			if (in_byte < SYM_OFFSET || in_byte[7]) begin
				res0.decode_error = 1'b1;
				res0.out_last = 1'b1;
				n_res = 2'd1;
				if (in_last) begin
					clr = 1'b1;
				end else begin
					st_next.discarding = 1'b1;
					st_next.phase = 2'd0;
				end
			end else begin
				ch = 6'(in_byte - SYM_OFFSET);
				if (!may0) begin
					if (!in_last) begin
						st_next.discarding = 1'b1;
						st_next.phase = 2'd1;
					end
				end else begin
					case (st.phase)
						2'd0: begin
							st_next.carry_bits = {ch, 2'b00};
							st_next.phase = 2'd1;
						end
						2'd1: begin
							res0.out_byte = st.carry_bits | {6'b000000, ch[5:4]};
							res0.out_valid = 1'b1;
							nd = 2'd1;
							st_next.carry_bits = {ch[3:0], 4'b0000};
							st_next.phase = 2'd2;
						end
						2'd2: begin
							res0.out_byte = st.carry_bits | {4'b0000, ch[5:2]};
							res0.out_valid = 1'b1;
							nd = 2'd1;
							st_next.carry_bits = {ch[1:0], 6'b000000};
							st_next.phase = 2'd3;
						end
						default: begin
							res0.out_byte = st.carry_bits | {2'b00, ch};
							res0.out_valid = 1'b1;
							nd = 2'd1;
							st_next.carry_bits = '0;
							st_next.phase = 2'd0;
						end
					endcase
				end
				fin = 1'b1;
			end
		end else begin
			if (may0) begin
				r = (st.phase == 2'd3) ? 2'd0 : st.phase;
				case (r)
					2'd0: begin
						made = st.carry_bits[5:0] | in_byte[7:2];
						rest = {in_byte[1:0], 4'b0000};
					end
					2'd1: begin
						made = st.carry_bits[5:0] | {2'b00, in_byte[7:4]};
						rest = {in_byte[3:0], 2'b00};
					end
					default: begin
						made = st.carry_bits[5:0] | {4'b0000, in_byte[7:6]};
						rest = in_byte[5:0];
					end
				endcase
				res0.out_byte = {2'b00, made} + SYM_OFFSET;
				res0.out_valid = 1'b1;
				nd = 2'd1;
				if (r < 2'd2) begin
					st_next.carry_bits = {2'b00, rest};
					st_next.phase = r + 2'd1;
				end else begin
					if (may1) begin
						res1.out_byte = {2'b00, rest} + SYM_OFFSET;
						res1.out_valid = 1'b1;
						nd = 2'd2;
					end
					st_next.carry_bits = '0;
					st_next.phase = 2'd0;
				end
				if (in_last && nd == 2'd1 && may1
						&& (st_next.phase == 2'd1 || st_next.phase == 2'd2)) begin
					res1.out_byte = {2'b00, st_next.carry_bits[5:0]} + SYM_OFFSET;
					res1.out_valid = 1'b1;
					nd = 2'd2;
				end
			end
			fin = 1'b1;
		end

		if (fin) begin
			n_res = nd;
			if (in_last) begin
				case (nd)
					2'd0: begin
						res0 = '0;
						res0.out_last = 1'b1;
						n_res = 2'd1;
					end
					2'd1: res0.out_last = 1'b1;
					default: res1.out_last = 1'b1;
				endcase
				clr = 1'b1;
			end
		end

		cnt_next = cnt + COUNT_WIDTH'(nd);
		if (clr) begin
			st_next  = '0;
			cnt_next = '0;
		end
	end

endmodule

// File: hw/rtl/sbtc_fifo.sv
module sbtc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  sbtc_pkg::result_t push0,
	input  sbtc_pkg::result_t push1,
	output logic              room2,
	output logic              rd_valid,
	input  logic              rd_ready,
	output sbtc_pkg::result_t rd_data
);
	import sbtc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   count_q;
	logic             pop;

	assign pop      = rd_valid && rd_ready;
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign room2    = (count_q <= (PTR_W+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + 1'b1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_W'(push_n);
			rp_q    <= rp_q + PTR_W'(pop);
			count_q <= count_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end

endmodule

// File: hw/rtl/six_bit_text_codec.sv
// Six-bit text codec. Encode mode (decode_mode = 0) packs each three bytes of a message into
// four symbols (six-bit value plus 0x3C) and flushes leftover bits at in_last; decode mode
// unpacks symbols into bytes and ends the message with an error result on a symbol outside
// 0x3C..0x7F. Data results per message are capped by output_limit. An input transaction is
// taken into an input register every cycle while the four-entry result buffer has room for
// two results; one result transaction leaves per cycle while out_ch.ready is high. Results
// pass through the input register and then the result buffer before they appear on out_ch.
module six_bit_text_codec #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sbtc_in_if.sink                         in_ch,
	sbtc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [sbtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbtc_pkg::CFG_W-1:0]      cfg_data
);
	import sbtc_pkg::*;

	codec_cfg_t             cfg_q;
	codec_state_t           st_q;
	codec_state_t           st_next;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_next;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       room2;
	logic       go;
	logic [1:0] n_res;
	logic [1:0] push_n;
	result_t    res0;
	result_t    res1;
	result_t    rd_data;

	assign go          = valid_s1 && room2;
	assign in_ch.ready = !valid_s1 || room2;
	assign push_n      = go ? n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_mode  <= 1'b0;
			cfg_q.output_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECODE_MODE:  cfg_q.decode_mode <= cfg_data[0];
				REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
		end else if (go) begin
			st_q  <= st_next;
			cnt_q <= cnt_next;
		end
	end

	sbtc_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.cfg      (cfg_q),
		.st       (st_q),
		.cnt      (cnt_q),
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.st_next  (st_next),
		.cnt_next (cnt_next),
		.n_res    (n_res),
		.res0     (res0),
		.res1     (res1)
	);

	sbtc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push0    (res0),
		.push1    (res1),
		.room2    (room2),
		.rd_valid (out_ch.valid),
		.rd_ready (out_ch.ready),
		.rd_data  (rd_data)
	);

	assign out_ch.out_byte     = rd_data.out_byte;
	assign out_ch.out_valid    = rd_data.out_valid;
	assign out_ch.out_last     = rd_data.out_last;
	assign out_ch.decode_error = rd_data.decode_error;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> (st_q == '0) && (cnt_q == '0))
		else $error("message state not cleared after final transaction");

	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		go && st_q.discarding && !last_s1 |-> n_res == 2'd0)
		else $error("result produced while discarding");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 && !st_q.discarding
		|-> n_res != 2'd0 && ((n_res == 2'd1) ? res0.out_last : res1.out_last))
		else $error("final transaction without last result");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		go && !last_s1 |=> cnt_q >= $past(cnt_q))
		else $error("emitted count went backward inside a message");
`endif

endmodule
